// ===== rtl/core/mgf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the MHD GLM flux unit.
package mgf_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = DATA_W + FRAC_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int GAMMA_W   = 18;
  localparam int CH_W      = 31;
  localparam int CFG_W     = 31;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [QUO_W-1:0]         quo_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t Q_ONE    = word_t'(1) <<< FRAC_W;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAMMA = 2'd0;
  localparam cfg_idx_t REG_CH    = 2'd1;
  localparam cfg_idx_t REG_GLM   = 2'd2;

  typedef struct packed {
    word_t density;
    word_t mom_x;
    word_t mom_y;
    word_t mom_z;
    word_t energy;
    word_t mag_x;
    word_t mag_y;
    word_t mag_z;
    word_t psi;
  } cell_t;

  typedef struct packed {
    word_t flux_density;
    word_t flux_mom_x;
    word_t flux_mom_y;
    word_t flux_mom_z;
    word_t flux_energy;
    word_t flux_mag_x;
    word_t flux_mag_y;
    word_t flux_mag_z;
    word_t flux_psi;
    logic  bad_density;
  } flux_t;

  function automatic word_t sat_wide(input logic signed [DATA_W:0] s);
    word_t r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b);
    logic signed [2*DATA_W-1:0]        p;
    logic signed [2*DATA_W-1:0]        adj;
    logic signed [2*DATA_W-FRAC_W-1:0] q;
    word_t                             r;
    p   = (2*DATA_W)'(a) * (2*DATA_W)'(b);
    adj = p[2*DATA_W-1] ? p + (2*DATA_W)'((64'd1 << FRAC_W) - 64'd1) : p;
    q   = adj[2*DATA_W-1:FRAC_W];
    if ((&q[2*DATA_W-FRAC_W-1:DATA_W-1]) || !(|q[2*DATA_W-FRAC_W-1:DATA_W-1])) begin
      r = q[DATA_W-1:0];
    end else begin
      r = q[2*DATA_W-FRAC_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  function automatic word_t halve(input word_t a);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {{DATA_W{1'b0}}, a[DATA_W-1]};
    return s[DATA_W:1];
  endfunction

  function automatic logic [DATA_W-1:0] magn(input word_t a);
    return a[DATA_W-1] ? -a : a;
  endfunction

  function automatic word_t div_sat(input quo_t q, input logic neg);
    word_t r;
    if ((|q[QUO_W-1:DATA_W]) || q[DATA_W-1]) begin
      r = neg ? WORD_MIN : WORD_MAX;
    end else begin
      r = neg ? -word_t'(q[DATA_W-1:0]) : word_t'(q[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mgf_divider.sv =====
// Pipelined restoring divider: three momenta over density, one quotient bit per stage.
module mgf_divider import mgf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  cell_t in_cell,
  output logic  out_valid,
  output cell_t out_cell,
  output quo_t  quo_x,
  output quo_t  quo_y,
  output quo_t  quo_z
);

  logic              vld  [0:DIV_STEPS];
  cell_t             side [0:DIV_STEPS];
  quo_t              num  [0:DIV_STEPS][3];
  logic [DATA_W-1:0] rem  [0:DIV_STEPS][3];
  quo_t              num_next [1:DIV_STEPS][3];
  logic [DATA_W-1:0] rem_next [1:DIV_STEPS][3];

  always_comb begin
    logic [DATA_W-1:0] r2;
    logic [DATA_W-1:0] dvs;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      dvs = side[k-1].density;
      for (int l = 0; l < 3; l++) begin
        r2 = {rem[k-1][l][DATA_W-2:0], num[k-1][l][QUO_W-1]};
        if (r2 >= dvs) begin
          rem_next[k][l] = r2 - dvs;
          num_next[k][l] = {num[k-1][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[k][l] = r2;
          num_next[k][l] = {num[k-1][l][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= DIV_STEPS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0]   <= in_cell;
      num[0][0] <= {magn(in_cell.mom_x), {FRAC_W{1'b0}}};
      num[0][1] <= {magn(in_cell.mom_y), {FRAC_W{1'b0}}};
      num[0][2] <= {magn(in_cell.mom_z), {FRAC_W{1'b0}}};
      for (int l = 0; l < 3; l++) rem[0][l] <= '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        side[k] <= side[k-1];
        for (int l = 0; l < 3; l++) begin
          num[k][l] <= num_next[k][l];
          rem[k][l] <= rem_next[k][l];
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_cell  = side[DIV_STEPS];
  assign quo_x     = num[DIV_STEPS][0];
  assign quo_y     = num[DIV_STEPS][1];
  assign quo_z     = num[DIV_STEPS][2];

endmodule

// ===== rtl/core/mgf_flux_core.sv =====
// Flux datapath after division: products, pressure and the nine flux terms.
module mgf_flux_core import mgf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  cell_t in_cell,
  input  quo_t  quo_x,
  input  quo_t  quo_y,
  input  quo_t  quo_z,
  input  word_t gm1,
  input  word_t chsq,
  input  logic  glm,
  output logic  out_valid,
  output flux_t out_flux
);

  localparam int NST = 11;

  typedef struct packed {
    cell_t c;
    logic  bad;
    word_t u1, u2, u3;
    word_t uu1, uu2, uu3, bxx, byy, bzz;
    word_t u1mx, u1my, u1mz, bxby, bxbz;
    word_t u1bx, u2by, u3bz, u1by, u2bx, u1bz, u3bx, chbx;
    word_t k, pb, a1, f2, f3, t, f6, f7;
    word_t km, e1, p, fx1, epp, ue, bt;
  } work_t;

  work_t st  [0:NST-1];
  work_t nxt [0:NST-1];
  logic  vld [0:NST];
  flux_t res;
  flux_t res_next;

  always_comb begin
    // saturate quotients into velocities
    nxt[0]     = st[0];
    nxt[0].c   = in_cell;
    nxt[0].bad = in_cell.density[DATA_W-1] || !(|in_cell.density);
    nxt[0].u1  = div_sat(quo_x, in_cell.mom_x[DATA_W-1]);
    nxt[0].u2  = div_sat(quo_y, in_cell.mom_y[DATA_W-1]);
    nxt[0].u3  = div_sat(quo_z, in_cell.mom_z[DATA_W-1]);

    nxt[1]      = st[0];
    nxt[1].uu1  = fx_mul(st[0].u1, st[0].u1);
    nxt[1].uu2  = fx_mul(st[0].u2, st[0].u2);
    nxt[1].uu3  = fx_mul(st[0].u3, st[0].u3);
    nxt[1].bxx  = fx_mul(st[0].c.mag_x, st[0].c.mag_x);
    nxt[1].byy  = fx_mul(st[0].c.mag_y, st[0].c.mag_y);
    nxt[1].bzz  = fx_mul(st[0].c.mag_z, st[0].c.mag_z);
    nxt[1].u1mx = fx_mul(st[0].u1, st[0].c.mom_x);
    nxt[1].u1my = fx_mul(st[0].u1, st[0].c.mom_y);
    nxt[1].u1mz = fx_mul(st[0].u1, st[0].c.mom_z);
    nxt[1].bxby = fx_mul(st[0].c.mag_x, st[0].c.mag_y);
    nxt[1].bxbz = fx_mul(st[0].c.mag_x, st[0].c.mag_z);
    nxt[1].u1bx = fx_mul(st[0].u1, st[0].c.mag_x);
    nxt[1].u2by = fx_mul(st[0].u2, st[0].c.mag_y);
    nxt[1].u3bz = fx_mul(st[0].u3, st[0].c.mag_z);
    nxt[1].u1by = fx_mul(st[0].u1, st[0].c.mag_y);
    nxt[1].u2bx = fx_mul(st[0].u2, st[0].c.mag_x);
    nxt[1].u1bz = fx_mul(st[0].u1, st[0].c.mag_z);
    nxt[1].u3bx = fx_mul(st[0].u3, st[0].c.mag_x);
    nxt[1].chbx = fx_mul(chsq, st[0].c.mag_x);

    nxt[2]    = st[1];
    nxt[2].k  = sat_add(st[1].uu1, st[1].uu2);
    nxt[2].pb = sat_add(st[1].bxx, st[1].byy);
    nxt[2].a1 = sat_sub(st[1].u1mx, st[1].bxx);
    nxt[2].f2 = sat_sub(st[1].u1my, st[1].bxby);
    nxt[2].f3 = sat_sub(st[1].u1mz, st[1].bxbz);
    nxt[2].t  = sat_add(st[1].u1bx, st[1].u2by);
    nxt[2].f6 = sat_sub(st[1].u1by, st[1].u2bx);
    nxt[2].f7 = sat_sub(st[1].u1bz, st[1].u3bx);

    nxt[3]    = st[2];
    nxt[3].k  = sat_add(st[2].k, st[2].uu3);
    nxt[3].pb = sat_add(st[2].pb, st[2].bzz);
    nxt[3].t  = sat_add(st[2].t, st[2].u3bz);

    nxt[4]    = st[3];
    nxt[4].pb = halve(st[3].pb);
    nxt[4].km = fx_mul(st[3].c.density, st[3].k);

    nxt[5]    = st[4];
    nxt[5].e1 = sat_sub(st[4].c.energy, halve(st[4].km));

    nxt[6]    = st[5];
    nxt[6].e1 = sat_sub(st[5].e1, st[5].pb);

    nxt[7]    = st[6];
    nxt[7].p  = fx_mul(gm1, st[6].e1);

    nxt[8]     = st[7];
    nxt[8].fx1 = sat_add(st[7].a1, st[7].p);
    nxt[8].epp = sat_add(st[7].c.energy, st[7].p);

    nxt[9]     = st[8];
    nxt[9].fx1 = sat_add(st[8].fx1, st[8].pb);
    nxt[9].epp = sat_add(st[8].epp, st[8].pb);

    nxt[10]    = st[9];
    nxt[10].ue = fx_mul(st[9].u1, st[9].epp);
    nxt[10].bt = fx_mul(st[9].c.mag_x, st[9].t);

    res_next.flux_density = st[10].c.mom_x;
    res_next.flux_mom_x   = st[10].fx1;
    res_next.flux_mom_y   = st[10].f2;
    res_next.flux_mom_z   = st[10].f3;
    res_next.flux_energy  = sat_sub(st[10].ue, st[10].bt);
    res_next.flux_mag_x   = glm ? st[10].c.psi : '0;
    res_next.flux_mag_y   = st[10].f6;
    res_next.flux_mag_z   = st[10].f7;
    res_next.flux_psi     = glm ? st[10].chbx : '0;
    res_next.bad_density  = st[10].bad;
    if (st[10].bad) begin
      res_next             = '0;
      res_next.bad_density = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NST; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= NST; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) st[i] <= nxt[i];
      res <= res_next;
    end
  end

  assign out_valid = vld[NST];
  assign out_flux  = res;

endmodule

// ===== rtl/core/mhd_glm_flux_unit.sv =====
// Top level of the ideal MHD x-direction flux unit with GLM cleaning.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   cell in  | item_valid, item_stall | density .. psi
//   flux out | flux_valid, flux_stall | flux_density .. flux_psi, bad_density
//   config   | cfg_write              | cfg_index, cfg_data
//
// One beat enters per cycle unless the output stalls; the path runs through the 49-stage
// divider (input register plus one quotient bit per stage) and 12 stages of multiply and add.
// Reset clears valid bits and loads the register defaults.
// A stalled output beat freezes the whole pipeline; item_stall follows it.
module mhd_glm_flux_unit import mgf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  word_t            density,
  input  word_t            mom_x,
  input  word_t            mom_y,
  input  word_t            mom_z,
  input  word_t            energy,
  input  word_t            mag_x,
  input  word_t            mag_y,
  input  word_t            mag_z,
  input  word_t            psi,
  output logic             flux_valid,
  input  logic             flux_stall,
  output word_t            flux_density,
  output word_t            flux_mom_x,
  output word_t            flux_mom_y,
  output word_t            flux_mom_z,
  output word_t            flux_energy,
  output word_t            flux_mag_x,
  output word_t            flux_mag_y,
  output word_t            flux_mag_z,
  output word_t            flux_psi,
  output logic             bad_density,
  input  logic             cfg_write,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [GAMMA_W-1:0] heat_ratio;
  logic [CH_W-1:0]    cleaning_speed;
  logic               glm_mode;
  word_t              gm1;
  word_t              chsq;
  logic               adv;
  cell_t              in_beat;
  logic               div_valid;
  cell_t              div_cell;
  quo_t               quo_x, quo_y, quo_z;
  flux_t              flux;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_ratio     <= GAMMA_W'(109227);
      cleaning_speed <= CH_W'(65536);
      glm_mode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAMMA: heat_ratio     <= cfg_data[GAMMA_W-1:0];
        REG_CH:    cleaning_speed <= cfg_data[CH_W-1:0];
        REG_GLM:   glm_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gm1  <= word_t'({{(DATA_W-GAMMA_W){1'b0}}, heat_ratio}) - Q_ONE;
    chsq <= fx_mul(word_t'({{(DATA_W-CH_W){1'b0}}, cleaning_speed}),
                   word_t'({{(DATA_W-CH_W){1'b0}}, cleaning_speed}));
  end

  assign adv        = !(flux_valid && flux_stall);
  assign item_stall = !adv;

  assign in_beat = '{density: density, mom_x: mom_x, mom_y: mom_y, mom_z: mom_z,
                     energy: energy, mag_x: mag_x, mag_y: mag_y, mag_z: mag_z, psi: psi};

  mgf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (item_valid),
    .in_cell   (in_beat),
    .out_valid (div_valid),
    .out_cell  (div_cell),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .quo_z     (quo_z)
  );

  mgf_flux_core u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_cell   (div_cell),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .quo_z     (quo_z),
    .gm1       (gm1),
    .chsq      (chsq),
    .glm       (glm_mode),
    .out_valid (flux_valid),
    .out_flux  (flux)
  );

  assign flux_density = flux.flux_density;
  assign flux_mom_x   = flux.flux_mom_x;
  assign flux_mom_y   = flux.flux_mom_y;
  assign flux_mom_z   = flux.flux_mom_z;
  assign flux_energy  = flux.flux_energy;
  assign flux_mag_x   = flux.flux_mag_x;
  assign flux_mag_y   = flux.flux_mag_y;
  assign flux_mag_z   = flux.flux_mag_z;
  assign flux_psi     = flux.flux_psi;
  assign bad_density  = flux.bad_density;

endmodule
